// ----- rtl/okle_pkg.sv -----
// Package: shared types, codes and defaults of the ordered key list engine.
`timescale 1ns / 1ps
`default_nettype none
package okle_pkg;

    localparam int OKLE_CAPACITY = 64;
    localparam int OKLE_KEY_BITS = 32;
    localparam logic [6:0] OKLE_LIMIT_RESET = 7'd64;

    localparam logic [2:0] CMD_INSERT    = 3'd0;
    localparam logic [2:0] CMD_INSERT_AT = 3'd1;
    localparam logic [2:0] CMD_DELETE_AT = 3'd2;
    localparam logic [2:0] CMD_DELETE    = 3'd3;
    localparam logic [2:0] CMD_FIND      = 3'd4;
    localparam logic [2:0] CMD_BFIND     = 3'd5;
    localparam logic [2:0] CMD_SORT      = 3'd6;
    localparam logic [2:0] CMD_READ      = 3'd7;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_EMPTY      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [2:0] ST_NOT_SORTED = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] key;
        logic [7:0]  position;
    } okle_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  found_position;
        logic [31:0] read_key;
        logic [6:0]  entry_count;
    } okle_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_LOC_RD,
        S_LOC_CMP,
        S_RM_RD,
        S_RM_WR,
        S_INS_PREP,
        S_INS_RD,
        S_INS_WR,
        S_SC_RD,
        S_SC_A,
        S_SC_B,
        S_BS_RD,
        S_BS_CMP,
        S_SO_OUT,
        S_SO_MIN0,
        S_SO_IN,
        S_SO_CMP,
        S_SO_SW1,
        S_SO_SW2,
        S_SO_SW3,
        S_RD_RD,
        S_RD_DATA,
        S_FINISH
    } okle_state_t;

endpackage
`default_nettype wire

// ----- rtl/ordered_key_list_engine_unit.sv -----
// Top level: ordered key list engine, one key memory with a read port and a write port under a command sequencer.
`timescale 1ns / 1ps
`default_nettype none
//
// Channel  | Signals                          | Direction | Transaction
// ---------+----------------------------------+-----------+-----------------------------
// req      | req_valid, req_ready, req        | in        | one command (cmd,key,position)
// rsp      | rsp_valid, rsp_ready, rsp        | out       | one result per command
// cfg      | cfg_valid, cfg_ready, cfg_data   | in        | write of list_limit
//
// Each command walks the key memory through its single read port and single
// write port, one entry at a time: find and delete scan linearly, insert first
// removes a duplicate, binary find first checks the order, and sort is a selection
// sort. Reset clears count and sets the limit to 64; the key memory is not cleared.
// A new command is taken only while the sequencer is idle; a result that waits
// on rsp_ready holds the sequencer in its last step.
//
module ordered_key_list_engine_unit
    import okle_pkg::*;
#(
    parameter int CAPACITY = OKLE_CAPACITY,
    parameter int KEY_BITS = OKLE_KEY_BITS
)(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire okle_req_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output okle_rsp_t      rsp,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic [6:0] cfg_data
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = (CW > 8) ? CW + 1 : 9;

    // key memory
    logic [KEY_BITS-1:0] mem [CAPACITY];
    logic [KEY_BITS-1:0] rdata_reg;
    logic [IW-1:0]       rd_addr;
    logic [IW-1:0]       wr_addr;
    logic [KEY_BITS-1:0] wr_data;
    logic                wr_en;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    okle_state_t         state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [CW-1:0]       m_reg, m_next;
    logic [2:0]          cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [7:0]          pos_reg, pos_next;
    logic [KEY_BITS-1:0] minv_reg, minv_next;
    logic [KEY_BITS-1:0] tv_reg, tv_next;
    logic [2:0]          st_reg, st_next;
    logic [6:0]          fpos_reg, fpos_next;
    logic [31:0]         rkey_reg, rkey_next;
    logic [6:0]          lim_reg;
    okle_rsp_t           out_reg, out_next;
    logic                ov_reg, ov_next;

    // widened views for compares against position and limit
    logic [WW-1:0] cnt_w, pos_w, lim_w, p_w;
    logic [CW-1:0] mid;

    always_comb
    begin
        cnt_w = WW'(cnt_reg);
        pos_w = WW'(pos_reg);
        lim_w = WW'(lim_reg);
        if (lim_w == '0)
        begin
            lim_w = WW'(1);
        end
        if (lim_w > WW'(CAPACITY))
        begin
            lim_w = WW'(CAPACITY);
        end
        p_w = (pos_w == '0) ? WW'(1) : pos_w;
        mid = i_reg + ((j_reg - i_reg) >> 1);
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg <= OKLE_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            lim_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        m_reg    <= m_next;
        cmd_reg  <= cmd_next;
        key_reg  <= key_next;
        pos_reg  <= pos_next;
        minv_reg <= minv_next;
        tv_reg   <= tv_next;
        st_reg   <= st_next;
        fpos_reg <= fpos_next;
        rkey_reg <= rkey_next;
        out_reg  <= out_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = ov_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        m_next     = m_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        pos_next   = pos_reg;
        minv_next  = minv_reg;
        tv_next    = tv_reg;
        st_next    = st_reg;
        fpos_next  = fpos_reg;
        rkey_next  = rkey_reg;
        out_next   = out_reg;
        ov_next    = ov_reg && !rsp_ready;
        rd_addr    = i_reg[IW-1:0];
        wr_addr    = i_reg[IW-1:0];
        wr_data    = rdata_reg;
        wr_en      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = req.cmd;
                    key_next   = KEY_BITS'(req.key);
                    pos_next   = req.position;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                st_next   = ST_OK;
                fpos_next = '0;
                rkey_next = '0;
                i_next    = '0;
                if (cmd_reg == CMD_INSERT || cmd_reg == CMD_INSERT_AT)
                begin
                    if (cnt_w >= lim_w)
                    begin
                        st_next    = ST_FULL;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_LOC_RD;
                    end
                end
                else if (cnt_reg == '0)
                begin
                    st_next    = ST_EMPTY;
                    state_next = S_FINISH;
                end
                else
                begin
                    case (cmd_reg) inside
                        CMD_DELETE_AT:
                        begin
                            if (pos_w == '0 || pos_w > cnt_w)
                            begin
                                st_next    = ST_NOT_FOUND;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                i_next     = CW'(pos_w - WW'(1));
                                state_next = S_RM_RD;
                            end
                        end
                        CMD_DELETE, CMD_FIND: state_next = S_LOC_RD;
                        CMD_BFIND:            state_next = S_SC_RD;
                        CMD_SORT:             state_next = S_SO_OUT;
                        default:
                        begin
                            if (pos_w == '0 || pos_w > cnt_w)
                            begin
                                st_next    = ST_NOT_FOUND;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_RD_RD;
                            end
                        end
                    endcase
                end
            end

            // linear search for key_reg
            S_LOC_RD:
            begin
                if (i_reg == cnt_reg)
                begin
                    if (cmd_reg == CMD_INSERT || cmd_reg == CMD_INSERT_AT)
                    begin
                        state_next = S_INS_PREP;
                    end
                    else
                    begin
                        st_next    = ST_NOT_FOUND;
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    rd_addr    = i_reg[IW-1:0];
                    state_next = S_LOC_CMP;
                end
            end

            S_LOC_CMP:
            begin
                if (rdata_reg == key_reg)
                begin
                    if (cmd_reg == CMD_FIND)
                    begin
                        fpos_next  = 7'(i_reg + 1'b1);
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_RM_RD;
                    end
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_LOC_RD;
                end
            end

            // close the gap at i_reg
            S_RM_RD:
            begin
                if ((i_reg + 1'b1) >= cnt_reg)
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (cmd_reg == CMD_INSERT || cmd_reg == CMD_INSERT_AT)
                    begin
                        state_next = S_INS_PREP;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    rd_addr    = IW'(i_reg + 1'b1);
                    state_next = S_RM_WR;
                end
            end

            S_RM_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = i_reg[IW-1:0];
                i_next     = i_reg + 1'b1;
                state_next = S_RM_RD;
            end

            S_INS_PREP:
            begin
                i_next = cnt_reg;
                if (cmd_reg == CMD_INSERT || p_w > cnt_w + WW'(1))
                begin
                    j_next = cnt_reg;
                end
                else
                begin
                    j_next = CW'(p_w - WW'(1));
                end
                state_next = S_INS_RD;
            end

            // open a slot at j_reg, shifting from the tail down
            S_INS_RD:
            begin
                if (i_reg == j_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = j_reg[IW-1:0];
                    wr_data    = key_reg;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    rd_addr    = IW'(i_reg - 1'b1);
                    state_next = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = i_reg[IW-1:0];
                i_next     = i_reg - 1'b1;
                state_next = S_INS_RD;
            end

            // strictly ascending check
            S_SC_RD:
            begin
                if ((i_reg + 1'b1) >= cnt_reg)
                begin
                    i_next     = '0;
                    j_next     = cnt_reg;
                    st_next    = ST_NOT_FOUND;
                    state_next = S_BS_RD;
                end
                else
                begin
                    rd_addr    = i_reg[IW-1:0];
                    state_next = S_SC_A;
                end
            end

            S_SC_A:
            begin
                tv_next    = rdata_reg;
                rd_addr    = IW'(i_reg + 1'b1);
                state_next = S_SC_B;
            end

            S_SC_B:
            begin
                if (!(tv_reg < rdata_reg))
                begin
                    st_next    = ST_NOT_SORTED;
                    state_next = S_FINISH;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_SC_RD;
                end
            end

            // binary search over [i_reg, j_reg)
            S_BS_RD:
            begin
                if (i_reg >= j_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    m_next     = mid;
                    rd_addr    = mid[IW-1:0];
                    state_next = S_BS_CMP;
                end
            end

            S_BS_CMP:
            begin
                if (rdata_reg == key_reg)
                begin
                    st_next    = ST_OK;
                    fpos_next  = 7'(m_reg + 1'b1);
                    state_next = S_FINISH;
                end
                else
                begin
                    if (key_reg < rdata_reg)
                    begin
                        j_next = m_reg;
                    end
                    else
                    begin
                        i_next = m_reg + 1'b1;
                    end
                    state_next = S_BS_RD;
                end
            end

            // selection sort
            S_SO_OUT:
            begin
                if ((i_reg + 1'b1) >= cnt_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    m_next     = i_reg;
                    j_next     = i_reg + 1'b1;
                    rd_addr    = i_reg[IW-1:0];
                    state_next = S_SO_MIN0;
                end
            end

            S_SO_MIN0:
            begin
                minv_next  = rdata_reg;
                state_next = S_SO_IN;
            end

            S_SO_IN:
            begin
                if (j_reg >= cnt_reg)
                begin
                    state_next = S_SO_SW1;
                end
                else
                begin
                    rd_addr    = j_reg[IW-1:0];
                    state_next = S_SO_CMP;
                end
            end

            S_SO_CMP:
            begin
                if (rdata_reg < minv_reg)
                begin
                    minv_next = rdata_reg;
                    m_next    = j_reg;
                end
                j_next     = j_reg + 1'b1;
                state_next = S_SO_IN;
            end

            S_SO_SW1:
            begin
                rd_addr    = i_reg[IW-1:0];
                state_next = S_SO_SW2;
            end

            S_SO_SW2:
            begin
                wr_en      = 1'b1;
                wr_addr    = m_reg[IW-1:0];
                state_next = S_SO_SW3;
            end

            S_SO_SW3:
            begin
                wr_en      = 1'b1;
                wr_addr    = i_reg[IW-1:0];
                wr_data    = minv_reg;
                i_next     = i_reg + 1'b1;
                state_next = S_SO_OUT;
            end

            S_RD_RD:
            begin
                rd_addr    = IW'(pos_w - WW'(1));
                state_next = S_RD_DATA;
            end

            S_RD_DATA:
            begin
                rkey_next  = 32'(rdata_reg);
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!ov_reg || rsp_ready)
                begin
                    out_next.status         = st_reg;
                    out_next.found_position = fpos_reg;
                    out_next.read_key       = rkey_reg;
                    out_next.entry_count    = 7'(cnt_reg);
                    ov_next                 = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
